@@ rtl/core/prime_modular_alu_core_assert.svh @@
// Assertion macros shared by the prime modular ALU RTL.
`ifndef PRIME_MODULAR_ALU_CORE_ASSERT_SVH
`define PRIME_MODULAR_ALU_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define PMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define PMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pma_pkg.sv @@
// Package with shared constants and types of the prime modular ALU.
package pma_pkg;

  localparam int WordBitsDef = 31;
  localparam logic [63:0] ModulusReset = 64'd1000000007;
  localparam int CmdBits = 2;
  localparam logic RegIdxModulus = 1'b0;

  typedef enum logic [CmdBits-1:0] {
    CMD_ADD = 2'd0,
    CMD_MUL = 2'd1,
    CMD_DIV = 2'd2,
    CMD_INV = 2'd3
  } cmd_e;

endpackage

@@ rtl/core/prime_modular_alu_core.sv @@
// Top level of the prime modular ALU: configuration register and sequenced arithmetic core.
//
//   Channel   Direction  Signals                    Content
//   s_axis    in         tvalid tready tdata tuser  operands, operation code
//   m_axis    out        tvalid tready tdata        result word
//   apb       in/out     psel penable pwrite ...    modulus register at address 0
//
// An add reduces both operands and then adds them; a multiply reduces both and forms the product.
// Inverse and divide run W squarings and up to W extra products, and divide one more product,
// each of W single-bit steps on the one shared step unit.
// W = WORD_BITS; with a modulus below two the result word is valid right after acceptance.
// The input side is not ready from acceptance until the result word is taken.
// Reset is asynchronous, active low, and loads the modulus with 1000000007.
`include "prime_modular_alu_core_assert.svh"

module prime_modular_alu_core #(
  parameter int WORD_BITS = pma_pkg::WordBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: operand_a, operand_b, zero padding.
  input  logic [((2*WORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // Fields from bit 0 up: cmd.
  input  logic [pma_pkg::CmdBits-1:0]            s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields from bit 0 up: result, zero padding.
  output logic [((WORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [((WORD_BITS > 32) ? 4 : 3)-1:0]  paddr,
  input  logic [((WORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((WORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                                   pready
);
  import pma_pkg::*;

  localparam int AddrBits = (WORD_BITS > 32) ? 4 : 3;
  localparam int DataBits = (WORD_BITS > 32) ? 64 : 32;
  localparam int OutBits  = ((WORD_BITS + 7) / 8) * 8;

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] result;

  pma_regs #(
    .WORD_BITS (WORD_BITS),
    .ADDR_BITS (AddrBits),
    .DATA_BITS (DataBits)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .modulus_o (modulus)
  );

  pma_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_i   (modulus),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .a_i         (s_axis_tdata[WORD_BITS-1:0]),
    .b_i         (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = OutBits'(result);

  `PMA_ASSERT_NOW(a_result_range, m_axis_tvalid, (result < modulus) || (result == '0), "result word not reduced below the modulus")
  `PMA_ASSERT_NOW(a_busy_while_out, m_axis_tvalid, !s_axis_tready, "input ready while a result word is pending")
  `PMA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accepting a word")

endmodule

@@ rtl/core/pma_regs.sv @@
// APB configuration register holding the modulus.
module pma_regs #(
  parameter int WORD_BITS = 31,
  parameter int ADDR_BITS = 3,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output logic [WORD_BITS-1:0] modulus_o
);
  import pma_pkg::*;

  logic                 sel_modulus;
  logic [WORD_BITS-1:0] modulus_q;

  assign sel_modulus = (paddr[ADDR_BITS-1] == RegIdxModulus);
  assign pready      = 1'b1;
  assign prdata      = sel_modulus ? DATA_BITS'(modulus_q) : '0;
  assign modulus_o   = modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset[WORD_BITS-1:0];
    end else if (psel && penable && pwrite && pready && sel_modulus) begin
      modulus_q <= pwdata[WORD_BITS-1:0];
    end
  end

endmodule

@@ rtl/core/pma_step.sv @@
// Shared step unit: doubles or passes the accumulator, adds, and reduces below the modulus.
module pma_step #(
  parameter int WORD_BITS = 31
) (
  input  logic                 shift_i,
  input  logic [WORD_BITS-1:0] acc_i,
  input  logic [WORD_BITS-1:0] addend_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  output logic [WORD_BITS-1:0] sum_o
);
  import pma_pkg::*;

  logic [WORD_BITS+1:0] base;
  logic [WORD_BITS+1:0] sum;
  logic [WORD_BITS+1:0] mod1;
  logic [WORD_BITS+1:0] mod2;
  logic [WORD_BITS+1:0] red;

  assign base = shift_i ? {1'b0, acc_i, 1'b0} : {2'b00, acc_i};
  assign sum  = base + {2'b00, addend_i};
  assign mod1 = {2'b00, modulus_i};
  assign mod2 = {1'b0, modulus_i, 1'b0};

  // Both inputs lie below the modulus, so the sum lies below three times it.
  always_comb begin
    priority if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
  end

  assign sum_o = red[WORD_BITS-1:0];

endmodule

@@ rtl/core/pma_ctrl.sv @@
// Sequencer that runs reductions, sums, products and Fermat exponentiation on the step unit.
module pma_ctrl #(
  parameter int WORD_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [WORD_BITS-1:0]         modulus_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pma_pkg::CmdBits-1:0]  cmd_i,
  input  logic [WORD_BITS-1:0]         a_i,
  input  logic [WORD_BITS-1:0]         b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [WORD_BITS-1:0]         result_o
);
  import pma_pkg::*;

  localparam int CntBits = $clog2(WORD_BITS);
  localparam logic [CntBits-1:0] CntTop = CntBits'(WORD_BITS - 1);
  localparam logic [CntBits-1:0] CntOne = CntBits'(1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RED_A = 8'b0000_0010,
    S_RED_B = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_SQ    = 8'b0001_0000,
    S_MX    = 8'b0010_0000,
    S_FMUL  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d, exp_next;
  cmd_e                 cmd_q, cmd_d;
  logic [WORD_BITS-1:0] ra_q, ra_d, rb_q, rb_d, pw_q, pw_d, p_q, p_d, res_q, res_d;
  logic [CntBits-1:0]   cnt_q, cnt_d, ecnt_q, ecnt_d;

  logic                 st_shift;
  logic [WORD_BITS-1:0] st_acc, st_add, st_sum;
  logic [WORD_BITS-1:0] expo, inv_base;
  logic                 last_bit, exp_last;

  pma_step #(.WORD_BITS(WORD_BITS)) u_step (
    .shift_i   (st_shift),
    .acc_i     (st_acc),
    .addend_i  (st_add),
    .modulus_i (modulus_i),
    .sum_o     (st_sum)
  );

  assign expo     = modulus_i - WORD_BITS'(2);
  assign last_bit = (cnt_q == '0);
  assign exp_last = (ecnt_q == '0);
  assign inv_base = (cmd_q == CMD_DIV) ? st_sum : ra_q;
  assign exp_next = exp_last ? ((cmd_q == CMD_DIV) ? S_FMUL : S_OUT) : S_SQ;

  always_comb begin
    st_shift = 1'b1;
    st_acc   = p_q;
    st_add   = '0;
    unique case (state_q)
      S_RED_A: st_add = WORD_BITS'(ra_q[cnt_q]);
      S_RED_B: st_add = WORD_BITS'(rb_q[cnt_q]);
      S_ADD: begin
        st_shift = 1'b0;
        st_acc   = ra_q;
        st_add   = rb_q;
      end
      S_SQ:   st_add = pw_q[cnt_q] ? pw_q : '0;
      S_MX:   st_add = pw_q[cnt_q] ? rb_q : '0;
      S_FMUL: st_add = pw_q[cnt_q] ? ra_q : '0;
      default: st_shift = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ra_d    = ra_q;
    rb_d    = rb_q;
    pw_d    = pw_q;
    p_d     = p_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    ecnt_d  = ecnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = cmd_e'(cmd_i);
          ra_d  = a_i;
          rb_d  = b_i;
          p_d   = '0;
          cnt_d = CntTop;
          if (modulus_i < WORD_BITS'(2)) begin
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_RED_A;
          end
        end
      end
      S_RED_A: begin
        p_d   = st_sum;
        cnt_d = cnt_q - CntOne;
        if (last_bit) begin
          ra_d    = st_sum;
          p_d     = '0;
          cnt_d   = CntTop;
          state_d = S_RED_B;
        end
      end
      S_RED_B: begin
        p_d   = st_sum;
        cnt_d = cnt_q - CntOne;
        if (last_bit) begin
          p_d   = '0;
          cnt_d = CntTop;
          rb_d  = st_sum;
          unique case (cmd_q)
            CMD_ADD: state_d = S_ADD;
            CMD_MUL: begin
              pw_d    = st_sum;
              state_d = S_FMUL;
            end
            CMD_DIV, CMD_INV: begin
              rb_d   = inv_base;
              pw_d   = WORD_BITS'(1);
              ecnt_d = CntTop;
              if (inv_base == '0) begin
                res_d   = '0;
                state_d = S_OUT;
              end else begin
                state_d = S_SQ;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        res_d   = st_sum;
        state_d = S_OUT;
      end
      S_SQ, S_MX: begin
        p_d   = st_sum;
        cnt_d = cnt_q - CntOne;
        if (last_bit) begin
          pw_d  = st_sum;
          res_d = st_sum;
          p_d   = '0;
          cnt_d = CntTop;
          if ((state_q == S_SQ) && expo[ecnt_q]) begin
            state_d = S_MX;
          end else begin
            ecnt_d  = exp_last ? ecnt_q : ecnt_q - CntOne;
            state_d = exp_next;
          end
        end
      end
      S_FMUL: begin
        p_d   = st_sum;
        cnt_d = cnt_q - CntOne;
        if (last_bit) begin
          res_d   = st_sum;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ecnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ecnt_q  <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
    pw_q  <= pw_d;
    p_q   <= p_d;
    res_q <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign result_o    = res_q;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the prime modular ALU core: stream traffic, modulus changes, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pma_pkg::*;

  localparam int WordBits = WordBitsDef;
  localparam int InBits = ((2 * WordBits + 7) / 8) * 8;
  localparam int OutBits = ((WordBits + 7) / 8) * 8;
  localparam logic [2:0] ModulusAddr = {RegIdxModulus, 2'b00};
  localparam logic [2:0] SpareAddr = {~RegIdxModulus, 2'b00};
  localparam int HoldCycles = 5000;
  localparam int SettleCycles = 2100;
  localparam int PhaseItems = 27;

  typedef logic [WordBits-1:0] word_t;

  class modular_result_board;
    word_t modulus;
    word_t pending_q[$];
    int unsigned checked;
    int unsigned errors;
    int unsigned op_seen[4];

    function new();
      modulus = ModulusReset[WordBits-1:0];
    endfunction

    function word_t mul_mod(word_t x, word_t y, word_t m);
      logic [63:0] prod;
      prod = 64'(x) * 64'(y);
      return word_t'(prod % 64'(m));
    endfunction

    function word_t fermat_inverse(word_t x, word_t m);
      word_t power;
      word_t acc;
      power = m - word_t'(2);
      acc = word_t'(1);
      if (x == '0) return '0;
      for (int i = WordBits - 1; i >= 0; i--) begin
        acc = mul_mod(acc, acc, m);
        if (power[i]) acc = mul_mod(acc, x, m);
      end
      return acc;
    endfunction

    function word_t modular_result(cmd_e cmd, word_t a, word_t b);
      word_t ra;
      word_t rb;
      logic [WordBits:0] sum;
      if (modulus < word_t'(2)) return '0;
      ra = a % modulus;
      rb = b % modulus;
      case (cmd)
        CMD_ADD: begin
          sum = {1'b0, ra} + {1'b0, rb};
          if (sum >= {1'b0, modulus}) sum = sum - {1'b0, modulus};
          return sum[WordBits-1:0];
        end
        CMD_MUL: return mul_mod(ra, rb, modulus);
        CMD_DIV: return mul_mod(ra, fermat_inverse(rb, modulus), modulus);
        default: return fermat_inverse(ra, modulus);
      endcase
    endfunction

    function void note_word(cmd_e cmd, word_t a, word_t b);
      pending_q = {pending_q, modular_result(cmd, a, b)};
      op_seen[cmd]++;
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10) $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_word(logic [OutBits-1:0] got);
      logic [OutBits-1:0] want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result word %0d with none expected", $time, got);
        return;
      end
      want = OutBits'(pending_q.pop_front());
      checked++;
      if (got !== want) report("result", 64'(want), 64'(got));
    endfunction

    function void check_modulus(logic [31:0] got);
      if (got !== 32'(modulus)) report("modulus readback", 64'(modulus), 64'(got));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // Fields from bit 0 up: operand_a, operand_b, zero padding.
  logic [InBits-1:0] s_axis_tdata = '0;
  // Fields from bit 0 up: cmd.
  logic [CmdBits-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // Fields from bit 0 up: result, zero padding.
  logic [OutBits-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic hold_req = 1'b0;
  logic quiet = 1'b0;
  int unsigned modulus_count = 0;
  modular_result_board board;

  prime_modular_alu_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 120);
  endfunction

  function automatic word_t pick_operand(word_t m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return m - word_t'(1);
      3: return m;
      4: return word_t'($urandom_range(0, 15));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input cmd_e cmd, input word_t a, input word_t b,
                           input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= InBits'({b, a});
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(cmd, a, b);
  endtask

  task automatic send_random(input word_t m);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 1) == 0) gap = pick_gap();
    send_word(cmd_e'($urandom_range(0, 3)), pick_operand(m), pick_operand(m), gap);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending_q.size() != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ModulusAddr) begin
      board.modulus = data[WordBits-1:0];
      modulus_count++;
    end
    @(posedge clk_i);
  endtask

  task automatic check_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ModulusAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.check_modulus(prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] setting, input int idx);
    apb_write(ModulusAddr, setting);
    check_readback();
    quiet = (idx % 4 == 1);
    for (int i = 0; i < PhaseItems; i++) begin
      if (idx == 2 && i == 4) hold_req = 1'b1;
      if (idx == 5 && i == 10) drain();
      send_random(board.modulus);
    end
    drain();
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
  end

  initial begin
    #8_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic [31:0] settings [10];
    word_t top;
    board = new();
    top = '1;
    settings = '{32'd998244353, 32'hFFFF_FFFF, 32'd3, 32'd65537, 32'd1000000,
                 32'd1000000007, 32'd7, 32'd2, 32'd1, ($urandom | 32'h1)};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_readback();
    send_word(CMD_ADD, top, top, 0);
    send_word(CMD_ADD, board.modulus - word_t'(1), word_t'(1), 0);
    send_word(CMD_MUL, top, top, 1);
    send_word(CMD_MUL, '0, word_t'(12345), 0);
    send_word(CMD_DIV, top, '0, 0);
    send_word(CMD_DIV, word_t'(5), board.modulus, 2);
    send_word(CMD_DIV, word_t'(1234567), word_t'(7654321), 0);
    send_word(CMD_INV, '0, top, 0);
    send_word(CMD_INV, board.modulus, '0, 0);
    send_word(CMD_INV, word_t'(1), '0, 3);
    send_word(CMD_INV, top, word_t'(77), 0);
    send_word(CMD_INV, board.modulus - word_t'(1), '0, 0);
    drain();

    apb_write(ModulusAddr, 32'd2);
    send_word(CMD_ADD, word_t'(1), word_t'(1), 0);
    send_word(CMD_MUL, word_t'(1), word_t'(1), 0);
    send_word(CMD_INV, word_t'(1), '0, 0);
    send_word(CMD_INV, '0, '0, 0);
    send_word(CMD_DIV, word_t'(1), word_t'(1), 0);
    send_word(CMD_DIV, word_t'(3), word_t'(2), 0);
    drain();

    apb_write(ModulusAddr, 32'h8000_0000);
    check_readback();
    send_word(CMD_ADD, top, top, 0);
    send_word(CMD_MUL, top, top, 0);
    send_word(CMD_DIV, top, word_t'(3), 0);
    send_word(CMD_INV, top, '0, 0);
    drain();

    apb_write(ModulusAddr, 32'd1);
    send_word(CMD_INV, word_t'(5), '0, 0);
    drain();

    apb_write(ModulusAddr, 32'h7FFF_FFFF);
    apb_write(SpareAddr, 32'd5);
    check_readback();
    send_word(CMD_INV, word_t'(3), '0, 0);
    send_word(CMD_MUL, top, word_t'(2), 0);
    drain();

    for (int p = 0; p < 10; p++) run_phase(settings[p], p);

    quiet = 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
    $display("Checked %0d result words over %0d modulus settings.",
             board.checked, modulus_count);
    $display("Operations add/mul/div/inv: %0d/%0d/%0d/%0d, including a long output stall.",
             board.op_seen[CMD_ADD], board.op_seen[CMD_MUL],
             board.op_seen[CMD_DIV], board.op_seen[CMD_INV]);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pma_pkg.sv
rtl/core/pma_regs.sv
rtl/core/pma_step.sv
rtl/core/pma_ctrl.sv
rtl/core/prime_modular_alu_core.sv
dv/tb_top.sv
